// File: design/kabf_pkg.sv
// ----------------------------------------------------------------------------
// Kalman angle/bias filter package
// Shared types and constants for the two-state Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W  = 31;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned FRAC_W = 16;

    localparam logic [IDX_W-1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;
    localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE   = 31'd197;
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE    = 31'd197;
    localparam logic [CFG_W-1:0] RST_MEASURE_NOISE = 31'd32768;
    localparam logic [CFG_W-1:0] RST_SAMPLE_PERIOD = 31'd655;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

    // Operations of the shared unit.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic                     start;
        t_op                      op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] res;
    } t_alu_rsp;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            sat32 = -32'sh8000_0000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

// File: design/kabf_alu.sv
// ----------------------------------------------------------------------------
// Kalman angle/bias filter arithmetic unit
// Shared saturating add, subtract, multiply (registered) and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kabf_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kabf_pkg::t_alu_req i_req,
    output kabf_pkg::t_alu_rsp o_rsp
);
    import kabf_pkg::*;

    localparam int unsigned QB = 48;

    logic signed [DATA_W-1:0] r_res;
    logic                     r_done;
    logic                     r_busy;
    logic [5:0]               r_cnt;
    logic [QB-1:0]            r_num;
    logic [QB-1:0]            r_quo;
    logic [DATA_W:0]          r_rem;
    logic [DATA_W-1:0]        r_den;
    logic                     r_neg;
    logic                     r_zero;

    logic signed [65:0] w_sum;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_rnd;
    logic [DATA_W:0]    w_trial;
    logic [QB-1:0]      w_quo;
    logic signed [65:0] w_q;
    logic [DATA_W-1:0]  w_abs;

    assign w_prod  = i_req.a * i_req.b;
    assign w_rnd   = (66'(w_prod) + 66'sd32768) >>> FRAC_W;
    assign w_trial = {r_rem[DATA_W-1:0], r_num[QB-1]};
    assign w_quo   = {r_quo[QB-2:0], (w_trial >= {1'b0, r_den})};
    assign w_q     = r_neg ? -$signed({18'd0, w_quo}) : $signed({18'd0, w_quo});
    assign w_abs   = i_req.a[DATA_W-1] ? 32'(-i_req.a) : i_req.a;

    always_comb begin
        w_sum = '0;
        if (i_req.op == OP_ADD) begin
            w_sum = 66'(i_req.a) + 66'(i_req.b);
        end else begin
            w_sum = 66'(i_req.a) - 66'(i_req.b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_num <= {r_num[QB-2:0], 1'b0};
                r_quo <= w_quo;
                r_rem <= (w_trial >= {1'b0, r_den}) ? w_trial - {1'b0, r_den} : w_trial;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= r_zero ? '0 : sat32(w_q);
                end
            end else if (i_req.start) begin
                unique case (i_req.op) inside
                    OP_ADD, OP_SUB: begin
                        r_res  <= sat32(w_sum);
                        r_done <= 1'b1;
                    end
                    OP_MUL: begin
                        r_res  <= sat32(w_rnd);
                        r_done <= 1'b1;
                    end
                    OP_DIV: begin
                        r_busy <= 1'b1;
                        r_cnt  <= 6'(QB);
                        r_num  <= {w_abs, 16'd0};
                        r_quo  <= '0;
                        r_rem  <= '0;
                        r_den  <= i_req.b;
                        r_neg  <= i_req.a[DATA_W-1];
                        r_zero <= (i_req.b[DATA_W-1] || i_req.b == '0);
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// File: design/kabf_seq.sv
// ----------------------------------------------------------------------------
// Kalman angle/bias filter sequencer
// Holds the filter state and steps the shared unit through one update.
// ----------------------------------------------------------------------------
module kabf_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [kabf_pkg::DATA_W-1:0] i_meas,
    input  logic signed [kabf_pkg::DATA_W-1:0] i_rate,
    input  logic [kabf_pkg::CFG_W-1:0]      i_qa,
    input  logic [kabf_pkg::CFG_W-1:0]      i_qb,
    input  logic [kabf_pkg::CFG_W-1:0]      i_r,
    input  logic [kabf_pkg::CFG_W-1:0]      i_dt,
    output logic                            o_busy,
    output logic                            o_done,
    output logic signed [kabf_pkg::DATA_W-1:0] o_angle,
    output logic signed [kabf_pkg::DATA_W-1:0] o_bias
);
    import kabf_pkg::*;

    localparam int unsigned NSTEP = 24;
    localparam int unsigned SW    = $clog2(NSTEP);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state   r_state;
    logic [SW-1:0] r_step;
    logic signed [DATA_W-1:0] r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic signed [DATA_W-1:0] r_meas, r_rate;
    logic signed [DATA_W-1:0] r_t0, r_t1, r_p00, r_p01, r_p10, r_p11, r_s, r_k0, r_k1, r_y;
    logic signed [DATA_W-1:0] w_dt, w_qa, w_qb, w_r;
    t_alu_req w_req;
    t_alu_rsp w_rsp;

    assign w_dt = $signed({1'b0, i_dt});
    assign w_qa = $signed({1'b0, i_qa});
    assign w_qb = $signed({1'b0, i_qb});
    assign w_r  = $signed({1'b0, i_r});

    kabf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_req.start = (r_state == S_ISSUE);
        w_req.op    = OP_ADD;
        w_req.a     = '0;
        w_req.b     = '0;
        unique case (r_step)
            5'd0:  begin w_req.op = OP_SUB; w_req.a = r_rate; w_req.b = r_bias; end
            5'd1:  begin w_req.op = OP_MUL; w_req.a = r_t0;   w_req.b = w_dt;   end
            5'd2:  begin w_req.op = OP_ADD; w_req.a = r_ang;  w_req.b = r_t0;   end
            5'd3:  begin w_req.op = OP_ADD; w_req.a = r_paa;  w_req.b = w_qa;   end
            5'd4:  begin w_req.op = OP_ADD; w_req.a = r_pab;  w_req.b = r_pba;  end
            5'd5:  begin w_req.op = OP_MUL; w_req.a = r_t1;   w_req.b = w_dt;   end
            5'd6:  begin w_req.op = OP_SUB; w_req.a = r_t0;   w_req.b = r_t1;   end
            5'd7:  begin w_req.op = OP_MUL; w_req.a = r_pbb;  w_req.b = w_dt;   end
            5'd8:  begin w_req.op = OP_SUB; w_req.a = r_pab;  w_req.b = r_t1;   end
            5'd9:  begin w_req.op = OP_SUB; w_req.a = r_pba;  w_req.b = r_t1;   end
            5'd10: begin w_req.op = OP_ADD; w_req.a = r_pbb;  w_req.b = w_qb;   end
            5'd11: begin w_req.op = OP_ADD; w_req.a = r_p00;  w_req.b = w_r;    end
            5'd12: begin w_req.op = OP_DIV; w_req.a = r_p00;  w_req.b = r_s;    end
            5'd13: begin w_req.op = OP_DIV; w_req.a = r_p10;  w_req.b = r_s;    end
            5'd14: begin w_req.op = OP_SUB; w_req.a = r_meas; w_req.b = r_ang;  end
            5'd15: begin w_req.op = OP_MUL; w_req.a = r_k0;   w_req.b = r_y;    end
            5'd16: begin w_req.op = OP_ADD; w_req.a = r_ang;  w_req.b = r_t0;   end
            5'd17: begin w_req.op = OP_MUL; w_req.a = r_k1;   w_req.b = r_y;    end
            5'd18: begin w_req.op = OP_ADD; w_req.a = r_bias; w_req.b = r_t0;   end
            5'd19: begin w_req.op = OP_MUL; w_req.a = r_k0;   w_req.b = r_p00;  end
            5'd20: begin w_req.op = OP_MUL; w_req.a = r_k0;   w_req.b = r_p01;  end
            5'd21: begin w_req.op = OP_MUL; w_req.a = r_k1;   w_req.b = r_p00;  end
            5'd22: begin w_req.op = OP_MUL; w_req.a = r_k1;   w_req.b = r_p01;  end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_ang   <= '0;
            r_bias  <= '0;
            r_paa   <= Q_ONE;
            r_pab   <= '0;
            r_pba   <= '0;
            r_pbb   <= Q_ONE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_meas  <= i_meas;
                        r_rate  <= i_rate;
                        r_step  <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        unique case (r_step) inside
                            5'd0, 5'd1, 5'd3, 5'd15, 5'd17: r_t0 <= w_rsp.res;
                            5'd2, 5'd16: r_ang <= w_rsp.res;
                            5'd4, 5'd5, 5'd7: r_t1 <= w_rsp.res;
                            5'd6:  r_p00 <= w_rsp.res;
                            5'd8:  r_p01 <= w_rsp.res;
                            5'd9:  r_p10 <= w_rsp.res;
                            5'd10: r_p11 <= w_rsp.res;
                            5'd11: r_s   <= w_rsp.res;
                            5'd12: r_k0  <= w_rsp.res;
                            5'd13: r_k1  <= w_rsp.res;
                            5'd14: r_y   <= w_rsp.res;
                            5'd18: r_bias <= w_rsp.res;
                            5'd19: r_paa <= sat32(66'(r_p00) - 66'(w_rsp.res));
                            5'd20: r_pab <= sat32(66'(r_p01) - 66'(w_rsp.res));
                            5'd21: r_pba <= sat32(66'(r_p10) - 66'(w_rsp.res));
                            5'd22: r_pbb <= sat32(66'(r_p11) - 66'(w_rsp.res));
                            default: begin end
                        endcase
                        if (r_step == SW'(NSTEP - 2)) begin
                            r_state <= S_IDLE;
                            o_done  <= 1'b1;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_angle = r_ang;
    assign o_bias  = r_bias;

endmodule

// File: design/kalman_angle_bias_filter_top.sv
// ----------------------------------------------------------------------------
// Kalman angle/bias filter top level
// Two-state Kalman filter fusing a tilt angle with a gyro rate, Q16.16.
// ----------------------------------------------------------------------------
// Input words carry measured_angle in tdata[31:0] and rate in tdata[63:32].
// Output words carry filtered_angle in tdata[31:0] and rate_bias in [63:32].
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write them only while idle, as the block itself does not enforce this.
// One word runs 23 operations through one shared arithmetic unit, of which
// the two divides take most of the time; no new word is taken meanwhile.
// s_axis_tready is low from acceptance until the result has been taken.
// The result stays in an output register until m_axis_tready is high.
// Reset restores the registers to their defaults, clears angle and bias and
// sets the covariance to the identity.
module kalman_angle_bias_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // measured_angle, rate
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // filtered_angle, rate_bias
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    import kabf_pkg::*;

    logic [CFG_W-1:0] r_qa, r_qb, r_r, r_dt;
    logic             r_ovalid;
    logic             w_busy, w_done, w_start;
    logic signed [DATA_W-1:0] w_ang, w_bias;

    assign s_axis_tready = !w_busy && !w_done && !r_ovalid;
    assign w_start       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_ANGLE_NOISE;
            r_qb <= RST_BIAS_NOISE;
            r_r  <= RST_MEASURE_NOISE;
            r_dt <= RST_SAMPLE_PERIOD;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ANGLE_NOISE:   r_qa <= i_cfg_data;
                    REG_BIAS_NOISE:    r_qb <= i_cfg_data;
                    REG_MEASURE_NOISE: r_r  <= i_cfg_data;
                    REG_SAMPLE_PERIOD: r_dt <= i_cfg_data;
                    default: begin end
                endcase
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    kabf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_meas  (s_axis_tdata[31:0]),
        .i_rate  (s_axis_tdata[63:32]),
        .i_qa    (r_qa),
        .i_qb    (r_qb),
        .i_r     (r_r),
        .i_dt    (r_dt),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_angle (w_ang),
        .o_bias  (w_bias)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {w_bias, w_ang};

endmodule

// File: design/kabf_checker.sv
// ----------------------------------------------------------------------------
// Kalman angle/bias filter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module kabf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after acceptance");

    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !m_axis_tvalid)
        else $error("result appeared too early");
endmodule

bind kalman_angle_bias_filter_top kabf_checker u_kabf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
